[src/stt_pkg.sv]
package stt_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT_FIRST,
    MODE_IDENT_MORE,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_COMMENT,
    MODE_BACKSLASH
  } mode_e;

  // token kinds
  localparam logic [3:0] KIND_SPACE    = 4'd0;
  localparam logic [3:0] KIND_NEWLINE  = 4'd1;
  localparam logic [3:0] KIND_STRING   = 4'd2;
  localparam logic [3:0] KIND_IDENT    = 4'd3;
  localparam logic [3:0] KIND_LBRACE   = 4'd4;
  localparam logic [3:0] KIND_RBRACE   = 4'd5;
  localparam logic [3:0] KIND_LPAREN   = 4'd6;
  localparam logic [3:0] KIND_RPAREN   = 4'd7;
  localparam logic [3:0] KIND_BS_LBRACE = 4'd8;
  localparam logic [3:0] KIND_BS_RBRACE = 4'd9;
  localparam logic [3:0] KIND_UNKNOWN  = 4'd10;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNTERM     = 2'd1;
  localparam logic [1:0] ERR_END_ESCAPE = 2'd2;
  localparam logic [1:0] ERR_BAD_ESCAPE = 2'd3;

  // characters
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_B    = 8'h62;
  localparam logic [7:0] CH_LOWER_N    = 8'h6E;
  localparam logic [7:0] CH_LOWER_R    = 8'h72;
  localparam logic [7:0] CH_LOWER_T    = 8'h74;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;

  // result queue
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;
  localparam int QUEUE_CNT_BITS = 3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  lexeme;
    logic [15:0] line;
    logic [15:0] column;
    logic        first_mark;
    logic        final_mark;
    logic [1:0]  err;
    logic        run_last;
  } result_t;

  // up to two results per input transaction
  typedef struct packed {
    logic [1:0] count;
    result_t    res1;
    result_t    res0;
  } scan_out_t;

endpackage

[src/stt_scan.sv]
module stt_scan #(
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [7:0]            text_byte_i,
  input  logic                  end_of_text_i,
  output stt_pkg::scan_out_t    scan_o
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  stt_pkg::mode_e            mode_q, mode_d;
  logic                      qsingle_q, qsingle_d;
  logic [POSITION_BITS-1:0]  line_q, line_d;
  logic [POSITION_BITS-1:0]  col_q, col_d;
  logic [POSITION_BITS-1:0]  sline_q, sline_d;
  logic [POSITION_BITS-1:0]  scol_q, scol_d;
  logic [7:0]                held_q, held_d;
  logic                      pend_q, pend_d;
  logic [31:0]               ppos_q, ppos_d;

  stt_pkg::result_t          res [2];
  logic [1:0]                n;

  function automatic logic [15:0] clip16(input logic [31:0] v);
    return (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= stt_pkg::CH_LOWER_A && c <= stt_pkg::CH_LOWER_Z) ||
           (c >= stt_pkg::CH_UPPER_A && c <= stt_pkg::CH_UPPER_Z) ||
           (c >= stt_pkg::CH_ZERO && c <= stt_pkg::CH_NINE) ||
           c == stt_pkg::CH_UNDERSCORE;
  endfunction

  function automatic stt_pkg::result_t mk(input logic [3:0] kind, input logic [7:0] lex,
                                          input logic [15:0] ln, input logic [15:0] cl,
                                          input logic fst, input logic fin,
                                          input logic [1:0] err);
    stt_pkg::result_t r;
    r.kind       = kind;
    r.lexeme     = lex;
    r.line       = ln;
    r.column     = cl;
    r.first_mark = fst;
    r.final_mark = fin;
    r.err        = err;
    r.run_last   = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic                     eot;
    logic [7:0]               b;
    logic [POSITION_BITS-1:0] col;
    logic [POSITION_BITS-1:0] ln;
    logic                     do_idle;
    logic                     closing;
    logic [3:0]               kind;
    logic [15:0]              sl16;
    logic [15:0]              sc16;

    mode_d    = mode_q;
    qsingle_d = qsingle_q;
    line_d    = line_q;
    col_d     = col_q;
    sline_d   = sline_q;
    scol_d    = scol_q;
    held_d    = held_q;
    pend_d    = pend_q;
    ppos_d    = ppos_q;
    res[0]    = '0;
    res[1]    = '0;
    n         = 2'd0;
    b         = text_byte_i;
    eot       = end_of_text_i || (b == stt_pkg::CH_NUL);
    col       = col_q;
    ln        = line_q;
    do_idle   = 1'b0;
    closing   = 1'b0;
    kind      = stt_pkg::KIND_UNKNOWN;
    sl16      = clip16(32'(sline_q));
    sc16      = clip16(32'(scol_q));

    if (eot) begin
      case (mode_q)
        stt_pkg::MODE_IDENT_FIRST, stt_pkg::MODE_IDENT_MORE: begin
          res[n[0]] = mk(stt_pkg::KIND_IDENT, held_q, sl16, sc16,
                         mode_q == stt_pkg::MODE_IDENT_FIRST, 1'b1, stt_pkg::ERR_NONE);
          n = n + 2'd1;
        end
        stt_pkg::MODE_STRING: begin
          res[n[0]] = mk(stt_pkg::KIND_STRING, 8'h00, sl16, sc16, 1'b0, 1'b1,
                         stt_pkg::ERR_UNTERM);
          n = n + 2'd1;
        end
        stt_pkg::MODE_ESCAPE: begin
          res[n[0]] = mk(stt_pkg::KIND_STRING, 8'h00, sl16, sc16, 1'b0, 1'b1,
                         stt_pkg::ERR_END_ESCAPE);
          n = n + 2'd1;
        end
        stt_pkg::MODE_BACKSLASH: begin
          res[n[0]] = mk(stt_pkg::KIND_UNKNOWN, stt_pkg::CH_BACKSLASH, sl16, sc16,
                         1'b1, 1'b1, stt_pkg::ERR_NONE);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      if (pend_q) begin
        res[n[0]] = mk(stt_pkg::KIND_SPACE, stt_pkg::CH_SPACE, ppos_q[31:16],
                       ppos_q[15:0], 1'b1, 1'b1, stt_pkg::ERR_NONE);
        n = n + 2'd1;
      end
      // back to the reset state for the next text
      mode_d    = stt_pkg::MODE_IDLE;
      qsingle_d = 1'b0;
      line_d    = '0;
      col_d     = '0;
      sline_d   = '0;
      scol_d    = '0;
      held_d    = 8'h00;
      pend_d    = 1'b0;
      ppos_d    = '0;
    end else begin
      if (b == stt_pkg::CH_LF) begin
        line_d = (line_q == POS_MAX) ? line_q : line_q + 1'b1;
        col    = '0;
      end
      col_d = (col == POS_MAX) ? col : col + 1'b1;
      ln    = line_d;

      case (mode_q)
        stt_pkg::MODE_COMMENT: begin
          do_idle = (b == stt_pkg::CH_LF);
        end
        stt_pkg::MODE_IDENT_FIRST, stt_pkg::MODE_IDENT_MORE: begin
          res[n[0]] = mk(stt_pkg::KIND_IDENT, held_q, sl16, sc16,
                         mode_q == stt_pkg::MODE_IDENT_FIRST, !is_ident(b),
                         stt_pkg::ERR_NONE);
          n = n + 2'd1;
          if (is_ident(b)) begin
            held_d = b;
            mode_d = stt_pkg::MODE_IDENT_MORE;
          end else begin
            held_d  = 8'h00;
            do_idle = 1'b1;
          end
        end
        stt_pkg::MODE_STRING: begin
          closing = qsingle_q ? (b == stt_pkg::CH_SQUOTE) : (b == stt_pkg::CH_DQUOTE);
          if (closing) begin
            res[n[0]] = mk(stt_pkg::KIND_STRING, b, sl16, sc16, 1'b0, 1'b1,
                           stt_pkg::ERR_NONE);
            n = n + 2'd1;
            mode_d = stt_pkg::MODE_IDLE;
          end else if (b == stt_pkg::CH_LF) begin
            res[n[0]] = mk(stt_pkg::KIND_STRING, 8'h00, sl16, sc16, 1'b0, 1'b1,
                           stt_pkg::ERR_UNTERM);
            n = n + 2'd1;
            do_idle = 1'b1;
          end else begin
            res[n[0]] = mk(stt_pkg::KIND_STRING, b, sl16, sc16, 1'b0, 1'b0,
                           stt_pkg::ERR_NONE);
            n = n + 2'd1;
            if (b == stt_pkg::CH_BACKSLASH) begin
              mode_d = stt_pkg::MODE_ESCAPE;
            end
          end
        end
        stt_pkg::MODE_ESCAPE: begin
          if (b == stt_pkg::CH_DQUOTE || b == stt_pkg::CH_SQUOTE ||
              b == stt_pkg::CH_LOWER_N || b == stt_pkg::CH_LOWER_B ||
              b == stt_pkg::CH_LOWER_R || b == stt_pkg::CH_BACKSLASH ||
              b == stt_pkg::CH_ZERO || b == stt_pkg::CH_LOWER_T) begin
            res[n[0]] = mk(stt_pkg::KIND_STRING, b, sl16, sc16, 1'b0, 1'b0,
                           stt_pkg::ERR_NONE);
            n = n + 2'd1;
            mode_d = stt_pkg::MODE_STRING;
          end else begin
            res[n[0]] = mk(stt_pkg::KIND_STRING, 8'h00, sl16, sc16, 1'b0, 1'b1,
                           stt_pkg::ERR_BAD_ESCAPE);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        stt_pkg::MODE_BACKSLASH: begin
          held_d = 8'h00;
          if (b == stt_pkg::CH_LBRACE || b == stt_pkg::CH_RBRACE) begin
            kind = (b == stt_pkg::CH_LBRACE) ? stt_pkg::KIND_BS_LBRACE
                                             : stt_pkg::KIND_BS_RBRACE;
            res[n[0]] = mk(kind, b, clip16(32'(ln)), clip16(32'(col)), 1'b1, 1'b1,
                           stt_pkg::ERR_NONE);
            n = n + 2'd1;
            mode_d = stt_pkg::MODE_IDLE;
          end else begin
            res[n[0]] = mk(stt_pkg::KIND_UNKNOWN, stt_pkg::CH_BACKSLASH, sl16, sc16,
                           1'b1, 1'b1, stt_pkg::ERR_NONE);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // fresh scan of the byte from the idle state
      if (do_idle) begin
        mode_d = stt_pkg::MODE_IDLE;
        if (b == stt_pkg::CH_SPACE) begin
          pend_d = 1'b1;
          ppos_d = {clip16(32'(ln)), clip16(32'(col))};
        end else if (b == stt_pkg::CH_TAB || b == stt_pkg::CH_CR) begin
          // dropped
        end else if (b == stt_pkg::CH_HASH) begin
          mode_d = stt_pkg::MODE_COMMENT;
        end else begin
          if (pend_d) begin
            res[n[0]] = mk(stt_pkg::KIND_SPACE, stt_pkg::CH_SPACE, ppos_d[31:16],
                           ppos_d[15:0], 1'b1, 1'b1, stt_pkg::ERR_NONE);
            n = n + 2'd1;
            pend_d = 1'b0;
          end
          if (b == stt_pkg::CH_LF) begin
            res[n[0]] = mk(stt_pkg::KIND_NEWLINE, b, clip16(32'(ln)), 16'h0000,
                           1'b1, 1'b1, stt_pkg::ERR_NONE);
            n = n + 2'd1;
          end else if (b == stt_pkg::CH_DQUOTE || b == stt_pkg::CH_SQUOTE) begin
            sline_d   = ln;
            scol_d    = col;
            qsingle_d = (b == stt_pkg::CH_SQUOTE);
            res[n[0]] = mk(stt_pkg::KIND_STRING, b, clip16(32'(ln)), clip16(32'(col)),
                           1'b1, 1'b0, stt_pkg::ERR_NONE);
            n = n + 2'd1;
            mode_d = stt_pkg::MODE_STRING;
          end else if (is_ident(b) || b == stt_pkg::CH_BACKSLASH) begin
            sline_d = ln;
            scol_d  = col;
            held_d  = b;
            mode_d  = is_ident(b) ? stt_pkg::MODE_IDENT_FIRST : stt_pkg::MODE_BACKSLASH;
          end else begin
            case (b)
              stt_pkg::CH_LBRACE: kind = stt_pkg::KIND_LBRACE;
              stt_pkg::CH_RBRACE: kind = stt_pkg::KIND_RBRACE;
              stt_pkg::CH_LPAREN: kind = stt_pkg::KIND_LPAREN;
              stt_pkg::CH_RPAREN: kind = stt_pkg::KIND_RPAREN;
              default:            kind = stt_pkg::KIND_UNKNOWN;
            endcase
            res[n[0]] = mk(kind, b, clip16(32'(ln)), clip16(32'(col)), 1'b1, 1'b1,
                           stt_pkg::ERR_NONE);
            n = n + 2'd1;
          end
        end
      end
    end

    if (n == 2'd1) begin
      res[0].run_last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].run_last = 1'b1;
    end
  end

  assign scan_o.count = n;
  assign scan_o.res0  = res[0];
  assign scan_o.res1  = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= stt_pkg::MODE_IDLE;
      qsingle_q <= 1'b0;
      line_q    <= '0;
      col_q     <= '0;
      sline_q   <= '0;
      scol_q    <= '0;
      held_q    <= 8'h00;
      pend_q    <= 1'b0;
      ppos_q    <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      qsingle_q <= qsingle_d;
      line_q    <= line_d;
      col_q     <= col_d;
      sline_q   <= sline_d;
      scol_q    <= scol_d;
      held_q    <= held_d;
      pend_q    <= pend_d;
      ppos_q    <= ppos_d;
    end
  end

endmodule

[src/stt_outq.sv]
module stt_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  stt_pkg::scan_out_t  scan_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                stall_i,
  output stt_pkg::result_t    head_o
);

  stt_pkg::result_t                    mem_q [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QUEUE_PTR_BITS-1:0]  wr_q, wr_d;
  logic [stt_pkg::QUEUE_PTR_BITS-1:0]  rd_q, rd_d;
  logic [stt_pkg::QUEUE_CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [stt_pkg::QUEUE_PTR_BITS-1:0]  wr_next;
  logic [stt_pkg::QUEUE_CNT_BITS-1:0]  push_n;
  logic                                pop;

  // two free slots needed before a transaction may enter
  assign room_o  = cnt_q <= stt_pkg::QUEUE_CNT_BITS'(stt_pkg::QUEUE_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign pop     = valid_o && !stall_i;
  assign push_n  = push_i ? stt_pkg::QUEUE_CNT_BITS'(scan_i.count) : '0;
  assign wr_next = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + stt_pkg::QUEUE_PTR_BITS'(push_n);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + push_n - stt_pkg::QUEUE_CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i && scan_i.count != 2'd0) begin
      mem_q[wr_q] <= scan_i.res0;
    end
    if (push_i && scan_i.count == 2'd2) begin
      mem_q[wr_next] <= scan_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stt_pkg::QUEUE_CNT_BITS'(stt_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o)
    else $error("push without two free slots");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[stt_pkg::QUEUE_PTR_BITS-1:0])
    else $error("queue pointers disagree with fill count");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && scan_i.count == 2'd2) |-> (scan_i.res1.run_last && !scan_i.res0.run_last))
    else $error("run_last misplaced in a two-result transaction");
`endif

endmodule

[src/source_text_tokenizer.sv]
// Source text tokenizer.
// Input channel (in_valid_i / in_stall_o): one source byte per transaction on
// text_byte_i; end_of_text_i, or a zero byte, closes the text, flushes any held
// identifier or backslash byte, pending space or open-string error, and returns all scan
// state (line/column counters included) to its reset values.
// Output channel (out_valid_o / out_stall_i): one lexeme byte per transaction
// with token kind, token start line/column, first/final marks and error code.
// last_of_run_o flags the final result produced by one input byte.
// The results of an accepted byte are registered and offered in order. One
// byte is accepted per cycle while the input is not stalled; each byte yields
// zero to two results, all computed in one pass and written to a 4-entry
// result queue. The input stalls while fewer than two queue slots are free.
// With a receiver that never stalls, a gapless stream of two-result bytes
// fills the queue faster than it drains, so the input stalls at times; a
// stalling receiver holds the input off until two slots are free again.
// Identifier bytes are held one byte, so an identifier's last byte comes out
// when the following byte arrives.
// Reset: asynchronous, active low; queue empty, scanner idle, counters zero.
// A receiver stall holds the head result steady until it is taken.
module source_text_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  lexeme_byte_o,
  output logic [15:0] token_line_o,
  output logic [15:0] token_column_o,
  output logic        token_first_o,
  output logic        token_final_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  stt_pkg::scan_out_t scan;
  stt_pkg::result_t   head;
  logic               room;
  logic               fire;

  assign in_stall_o = !room;
  assign fire       = in_valid_i && room;

  // scanner: state registers plus single-pass next-state/result logic
  stt_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .text_byte_i  (text_byte_i),
    .end_of_text_i(end_of_text_i),
    .scan_o       (scan)
  );

  // result queue parts the scanner from the receiver
  stt_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fire),
    .scan_i (scan),
    .room_o (room),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .head_o (head)
  );

  assign token_kind_o   = head.kind;
  assign lexeme_byte_o  = head.lexeme;
  assign token_line_o   = head.line;
  assign token_column_o = head.column;
  assign token_first_o  = head.first_mark;
  assign token_final_o  = head.final_mark;
  assign error_code_o   = head.err;
  assign last_of_run_o  = head.run_last;

endmodule

[tb/source_text_tokenizer_tb.sv]
`timescale 1ns / 1ps

module source_text_tokenizer_tb;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int PHASE_BYTES    = 52;     // random bytes per idling phase
  localparam int HOLD_CYCLES    = 150;    // long receiver hold-off
  localparam int POS_MAX        = 65535;
  localparam int SETTLE_CYCLES  = 4;      // idle margin after draining
  localparam int MAX_REPORTS    = 10;

  // One byte of stimulus. Rows with a typed expectation cause exactly one
  // result, which replaces the model's prediction for that byte.
  typedef struct {
    logic [7:0]       ch;
    logic             eot;
    bit               typed;
    stt_pkg::result_t exp;
  } stim_row_t;

  localparam stt_pkg::result_t NO_LEXEME = '0;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  text_byte_i;
  logic        end_of_text_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [3:0]  token_kind_o;
  logic [7:0]  lexeme_byte_o;
  logic [15:0] token_line_o;
  logic [15:0] token_column_o;
  logic        token_first_o;
  logic        token_final_o;
  logic [1:0]  error_code_o;
  logic        last_of_run_o;

  source_text_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .lexeme_byte_o  (lexeme_byte_o),
    .token_line_o   (token_line_o),
    .token_column_o (token_column_o),
    .token_first_o  (token_first_o),
    .token_final_o  (token_final_o),
    .error_code_o   (error_code_o),
    .last_of_run_o  (last_of_run_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer model state
  // ---------------------------------------------------------------------------
  stt_pkg::mode_e scan_state;
  bit          quote_single;
  int unsigned line_pos;      // saturating line counter
  int unsigned col_pos;       // saturating column counter
  int unsigned tok_line;      // start of the open token
  int unsigned tok_col;
  logic [7:0]  held_char;     // identifier / backslash lookahead byte
  bit          held_flag;
  bit          space_pend;    // collapsed space run waiting for the next token
  logic [15:0] space_line;
  logic [15:0] space_col;
  bit          fail_seen;     // sticky string failure

  stt_pkg::result_t byte_lexemes[$];     // results of the byte being modeled
  stt_pkg::result_t pending_lexemes[$];  // predicted, not yet seen at the output
  stim_row_t        byte_notes[$];       // per-byte info, in acceptance order

  int unsigned items_fed;
  int unsigned lexemes_checked;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  int sender_idle_pct;
  int recv_stall_pct;
  int hold_tag;         // bumped by the sequencer to request a hold-off
  int hold_seen;
  int hold_left;

  function automatic logic [15:0] clip_pos(int unsigned v);
    return (v > POS_MAX) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic int unsigned sat_inc(int unsigned v);
    return (v < POS_MAX) ? v + 1 : POS_MAX;
  endfunction

  function automatic bit is_word_char(logic [7:0] b);
    return (b >= stt_pkg::CH_LOWER_A && b <= stt_pkg::CH_LOWER_Z) ||
           (b >= stt_pkg::CH_UPPER_A && b <= stt_pkg::CH_UPPER_Z) ||
           (b >= stt_pkg::CH_ZERO && b <= stt_pkg::CH_NINE) || b == stt_pkg::CH_UNDERSCORE;
  endfunction

  function automatic void add_lexeme(logic [3:0] kind, logic [7:0] lex, int unsigned ln,
                                     int unsigned col, bit first, bit fin, logic [1:0] err);
    stt_pkg::result_t r;
    r.kind       = kind;
    r.lexeme     = lex;
    r.line       = clip_pos(ln);
    r.column     = clip_pos(col);
    r.first_mark = first;
    r.final_mark = fin;
    r.err        = err;
    r.run_last   = 1'b0;
    byte_lexemes = {byte_lexemes, r};
  endfunction

  function automatic void flush_space();
    if (space_pend) begin
      add_lexeme(stt_pkg::KIND_SPACE, stt_pkg::CH_SPACE, 32'(space_line), 32'(space_col),
                 1'b1, 1'b1, stt_pkg::ERR_NONE);
      space_pend = 1'b0;
    end
  endfunction

  // Error lexeme closes the string at its start position, byte is don't-care 0
  function automatic void string_fail(logic [1:0] code);
    add_lexeme(stt_pkg::KIND_STRING, stt_pkg::CH_NUL, tok_line, tok_col, 1'b0, 1'b1, code);
    fail_seen = 1'b1;
  endfunction

  function automatic void clear_scanner();
    scan_state   = stt_pkg::MODE_IDLE;
    quote_single = 1'b0;
    line_pos     = 0;
    col_pos      = 0;
    tok_line     = 0;
    tok_col      = 0;
    held_char    = 8'h00;
    held_flag    = 1'b0;
    space_pend   = 1'b0;
    space_line   = 16'h0000;
    space_col    = 16'h0000;
    fail_seen    = 1'b0;
  endfunction

  // A byte seen with no token open
  function automatic void idle_char(logic [7:0] b, int unsigned ln, int unsigned col);
    logic [3:0] kind;
    scan_state = stt_pkg::MODE_IDLE;
    if (b == stt_pkg::CH_SPACE) begin
      // later spaces overwrite the position: run keeps the last one
      space_pend = 1'b1;
      space_line = clip_pos(ln);
      space_col  = clip_pos(col);
    end else if (b == stt_pkg::CH_TAB || b == stt_pkg::CH_CR) begin
      // skipped, run of spaces stays open
    end else if (b == stt_pkg::CH_HASH) begin
      scan_state = stt_pkg::MODE_COMMENT;
    end else if (b == stt_pkg::CH_LF) begin
      flush_space();
      add_lexeme(stt_pkg::KIND_NEWLINE, b, ln, 0, 1'b1, 1'b1, stt_pkg::ERR_NONE);
    end else if (b == stt_pkg::CH_DQUOTE || b == stt_pkg::CH_SQUOTE) begin
      flush_space();
      tok_line     = ln;
      tok_col      = col;
      quote_single = (b == stt_pkg::CH_SQUOTE);
      add_lexeme(stt_pkg::KIND_STRING, b, ln, col, 1'b1, 1'b0, stt_pkg::ERR_NONE);
      scan_state   = stt_pkg::MODE_STRING;
    end else if (is_word_char(b)) begin
      flush_space();
      tok_line   = ln;
      tok_col    = col;
      held_char  = b;
      held_flag  = 1'b1;
      scan_state = stt_pkg::MODE_IDENT_FIRST;
    end else if (b == stt_pkg::CH_BACKSLASH) begin
      flush_space();
      tok_line   = ln;
      tok_col    = col;
      held_char  = b;
      held_flag  = 1'b1;
      scan_state = stt_pkg::MODE_BACKSLASH;
    end else begin
      case (b)
        stt_pkg::CH_LBRACE: kind = stt_pkg::KIND_LBRACE;
        stt_pkg::CH_RBRACE: kind = stt_pkg::KIND_RBRACE;
        stt_pkg::CH_LPAREN: kind = stt_pkg::KIND_LPAREN;
        stt_pkg::CH_RPAREN: kind = stt_pkg::KIND_RPAREN;
        default:            kind = stt_pkg::KIND_UNKNOWN;
      endcase
      flush_space();
      add_lexeme(kind, b, ln, col, 1'b1, 1'b1, stt_pkg::ERR_NONE);
    end
  endfunction

  // Model one accepted byte and queue the lexemes it should produce
  function automatic void tokenize_byte(stim_row_t note);
    logic [7:0]  b;
    int unsigned ln;
    int unsigned col;
    b = note.ch;
    byte_lexemes.delete();
    if (note.eot || b == stt_pkg::CH_NUL) begin
      case (scan_state)
        stt_pkg::MODE_IDENT_FIRST, stt_pkg::MODE_IDENT_MORE:
          add_lexeme(stt_pkg::KIND_IDENT, held_char, tok_line, tok_col,
                     scan_state == stt_pkg::MODE_IDENT_FIRST, 1'b1, stt_pkg::ERR_NONE);
        stt_pkg::MODE_STRING:    string_fail(stt_pkg::ERR_UNTERM);
        stt_pkg::MODE_ESCAPE:    string_fail(stt_pkg::ERR_END_ESCAPE);
        stt_pkg::MODE_BACKSLASH: add_lexeme(stt_pkg::KIND_UNKNOWN, stt_pkg::CH_BACKSLASH,
                                            tok_line, tok_col, 1'b1, 1'b1,
                                            stt_pkg::ERR_NONE);
        default: ;
      endcase
      flush_space();
      clear_scanner();
    end else begin
      // newline sits at column 0 of the new line
      if (b == stt_pkg::CH_LF) begin
        line_pos = sat_inc(line_pos);
        col      = 0;
      end else begin
        col = col_pos;
      end
      col_pos = sat_inc(col);
      ln      = line_pos;
      case (scan_state)
        stt_pkg::MODE_COMMENT: begin
          if (b == stt_pkg::CH_LF) idle_char(b, ln, col);
        end
        stt_pkg::MODE_IDENT_FIRST, stt_pkg::MODE_IDENT_MORE: begin
          if (is_word_char(b)) begin
            add_lexeme(stt_pkg::KIND_IDENT, held_char, tok_line, tok_col,
                       scan_state == stt_pkg::MODE_IDENT_FIRST, 1'b0, stt_pkg::ERR_NONE);
            held_char  = b;
            scan_state = stt_pkg::MODE_IDENT_MORE;
          end else begin
            add_lexeme(stt_pkg::KIND_IDENT, held_char, tok_line, tok_col,
                       scan_state == stt_pkg::MODE_IDENT_FIRST, 1'b1, stt_pkg::ERR_NONE);
            held_flag = 1'b0;
            held_char = 8'h00;
            idle_char(b, ln, col);
          end
        end
        stt_pkg::MODE_STRING: begin
          if (b == (quote_single ? stt_pkg::CH_SQUOTE : stt_pkg::CH_DQUOTE)) begin
            add_lexeme(stt_pkg::KIND_STRING, b, tok_line, tok_col, 1'b0, 1'b1,
                       stt_pkg::ERR_NONE);
            scan_state = stt_pkg::MODE_IDLE;
          end else if (b == stt_pkg::CH_LF) begin
            string_fail(stt_pkg::ERR_UNTERM);
            idle_char(b, ln, col);
          end else begin
            add_lexeme(stt_pkg::KIND_STRING, b, tok_line, tok_col, 1'b0, 1'b0,
                       stt_pkg::ERR_NONE);
            if (b == stt_pkg::CH_BACKSLASH) scan_state = stt_pkg::MODE_ESCAPE;
          end
        end
        stt_pkg::MODE_ESCAPE: begin
          if (b inside {stt_pkg::CH_DQUOTE, stt_pkg::CH_SQUOTE, stt_pkg::CH_LOWER_N,
                        stt_pkg::CH_LOWER_B, stt_pkg::CH_LOWER_R, stt_pkg::CH_BACKSLASH,
                        stt_pkg::CH_ZERO, stt_pkg::CH_LOWER_T}) begin
            add_lexeme(stt_pkg::KIND_STRING, b, tok_line, tok_col, 1'b0, 1'b0,
                       stt_pkg::ERR_NONE);
            scan_state = stt_pkg::MODE_STRING;
          end else begin
            // bad escape: report, then rescan the offending byte
            string_fail(stt_pkg::ERR_BAD_ESCAPE);
            idle_char(b, ln, col);
          end
        end
        stt_pkg::MODE_BACKSLASH: begin
          held_flag = 1'b0;
          held_char = 8'h00;
          if (b == stt_pkg::CH_LBRACE) begin
            add_lexeme(stt_pkg::KIND_BS_LBRACE, b, ln, col, 1'b1, 1'b1, stt_pkg::ERR_NONE);
            scan_state = stt_pkg::MODE_IDLE;
          end else if (b == stt_pkg::CH_RBRACE) begin
            add_lexeme(stt_pkg::KIND_BS_RBRACE, b, ln, col, 1'b1, 1'b1, stt_pkg::ERR_NONE);
            scan_state = stt_pkg::MODE_IDLE;
          end else begin
            add_lexeme(stt_pkg::KIND_UNKNOWN, stt_pkg::CH_BACKSLASH, tok_line, tok_col,
                       1'b1, 1'b1, stt_pkg::ERR_NONE);
            idle_char(b, ln, col);
          end
        end
        default: idle_char(b, ln, col);
      endcase
    end
    if (note.typed) begin
      byte_lexemes = {note.exp};
    end else if (byte_lexemes.size() > 0) begin
      byte_lexemes[byte_lexemes.size() - 1].run_last = 1'b1;
    end
    pending_lexemes = {pending_lexemes, byte_lexemes};
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: model accepted bytes, check accepted lexemes (sampled at posedge)
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    stt_pkg::result_t got;
    stt_pkg::result_t want;
    if (rst_ni) begin
      if (in_valid_i === 1'b1 && in_stall_o === 1'b0) begin
        tokenize_byte(byte_notes.pop_front());
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got.kind       = token_kind_o;
        got.lexeme     = lexeme_byte_o;
        got.line       = token_line_o;
        got.column     = token_column_o;
        got.first_mark = token_first_o;
        got.final_mark = token_final_o;
        got.err        = error_code_o;
        got.run_last   = last_of_run_o;
        lexemes_checked++;
        if (pending_lexemes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected lexeme kind=%0d byte=%h line=%0d col=%0d", $realtime,
                     got.kind, got.lexeme, got.line, got.column);
        end else begin
          want = pending_lexemes.pop_front();
          if (got.kind !== want.kind || got.lexeme !== want.lexeme ||
              got.line !== want.line || got.column !== want.column ||
              got.first_mark !== want.first_mark || got.final_mark !== want.final_mark ||
              got.err !== want.err || got.run_last !== want.run_last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("%0t: lexeme mismatch (kind byte line col first final err last)",
                       $realtime);
              $display("  expected %0d %h %0d %0d %b %b %0d %b", want.kind, want.lexeme,
                       want.line, want.column, want.first_mark, want.final_mark,
                       want.err, want.run_last);
              $display("  actual   %0d %h %0d %0d %b %b %0d %b", got.kind, got.lexeme,
                       got.line, got.column, got.first_mark, got.final_mark,
                       got.err, got.run_last);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on request (counted here)
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lexemes outstanding", cycle_count,
               pending_lexemes.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Entered and left at a falling edge. Valid stays high until the transaction
  // is taken; an idle gap lowers it first, in a step of its own.
  task automatic feed_byte(input logic [7:0] ch, input logic eot,
                           input bit typed = 1'b0,
                           input stt_pkg::result_t exp = NO_LEXEME);
    int        gap;
    stim_row_t note;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    note.ch    = ch;
    note.eot   = eot;
    note.typed = typed;
    note.exp   = exp;
    byte_notes = {byte_notes, note};
    in_valid_i    <= 1'b1;
    text_byte_i   <= ch;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    items_fed++;
    @(negedge clk_i);
  endtask

  // Pause the sender until every predicted lexeme has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_lexemes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [7:0] rand_word_char();
    int unsigned r;
    r = $urandom_range(62);
    if (r < 26) return stt_pkg::CH_LOWER_A + 8'(r);
    if (r < 52) return stt_pkg::CH_UPPER_A + 8'(r - 26);
    if (r < 62) return stt_pkg::CH_ZERO + 8'(r - 52);
    return stt_pkg::CH_UNDERSCORE;
  endfunction

  // printable string body byte, no quote or backslash
  function automatic logic [7:0] rand_plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(126, 32));
    while (c == stt_pkg::CH_DQUOTE || c == stt_pkg::CH_SQUOTE || c == stt_pkg::CH_BACKSLASH);
    return c;
  endfunction

  // Mostly well-formed tokens with random content, some noise and breakage
  task automatic feed_random_token();
    logic [7:0] esc_ok [8];
    logic [7:0] c;
    logic [7:0] q;
    int         pick;
    int         len;
    esc_ok = '{stt_pkg::CH_DQUOTE, stt_pkg::CH_SQUOTE, stt_pkg::CH_LOWER_N,
               stt_pkg::CH_LOWER_B, stt_pkg::CH_LOWER_R, stt_pkg::CH_BACKSLASH,
               stt_pkg::CH_ZERO, stt_pkg::CH_LOWER_T};
    pick = $urandom_range(99);
    if (pick < 22) begin
      len = $urandom_range(8, 1);
      repeat (len) feed_byte(rand_word_char(), 1'b0);
    end else if (pick < 34) begin
      // space run, sometimes broken up by skipped bytes
      len = $urandom_range(3, 1);
      repeat (len) begin
        feed_byte(stt_pkg::CH_SPACE, 1'b0);
        if ($urandom_range(3) == 0)
          feed_byte($urandom_range(1) ? stt_pkg::CH_TAB : stt_pkg::CH_CR, 1'b0);
      end
    end else if (pick < 42) begin
      feed_byte(stt_pkg::CH_LF, 1'b0);
    end else if (pick < 52) begin
      case ($urandom_range(3))
        0: c = stt_pkg::CH_LBRACE;
        1: c = stt_pkg::CH_RBRACE;
        2: c = stt_pkg::CH_LPAREN;
        default: c = stt_pkg::CH_RPAREN;
      endcase
      feed_byte(c, 1'b0);
    end else if (pick < 70) begin
      q = $urandom_range(1) ? stt_pkg::CH_SQUOTE : stt_pkg::CH_DQUOTE;
      feed_byte(q, 1'b0);
      len = $urandom_range(6);
      repeat (len) begin
        pick = $urandom_range(99);
        if (pick < 78) begin
          feed_byte(rand_plain_char(), 1'b0);
        end else if (pick < 94) begin
          feed_byte(stt_pkg::CH_BACKSLASH, 1'b0);
          feed_byte(esc_ok[3'($urandom_range(7))], 1'b0);
        end else begin
          feed_byte(stt_pkg::CH_BACKSLASH, 1'b0);
          do c = 8'($urandom_range(255, 1));
          while (c inside {stt_pkg::CH_DQUOTE, stt_pkg::CH_SQUOTE, stt_pkg::CH_LOWER_N,
                           stt_pkg::CH_LOWER_B, stt_pkg::CH_LOWER_R, stt_pkg::CH_BACKSLASH,
                           stt_pkg::CH_ZERO, stt_pkg::CH_LOWER_T});
          feed_byte(c, 1'b0);
        end
      end
      // a few strings are left open or cut by a newline
      pick = $urandom_range(99);
      if (pick < 88) feed_byte(q, 1'b0);
      else if (pick < 94) feed_byte(stt_pkg::CH_LF, 1'b0);
    end else if (pick < 78) begin
      feed_byte(stt_pkg::CH_HASH, 1'b0);
      len = $urandom_range(5);
      repeat (len) begin
        do c = 8'($urandom_range(255, 1));
        while (c == stt_pkg::CH_LF);
        feed_byte(c, 1'b0);
      end
      feed_byte(stt_pkg::CH_LF, 1'b0);
    end else if (pick < 85) begin
      feed_byte(stt_pkg::CH_BACKSLASH, 1'b0);
      pick = $urandom_range(2);
      if (pick == 0) feed_byte(stt_pkg::CH_LBRACE, 1'b0);
      else if (pick == 1) feed_byte(stt_pkg::CH_RBRACE, 1'b0);
      else feed_byte(8'($urandom_range(255, 1)), 1'b0);
    end else if (pick < 97) begin
      feed_byte(8'($urandom_range(255, 1)), 1'b0);
    end else begin
      // end of text: marker with a junk byte, or a zero byte
      if ($urandom_range(1)) feed_byte(8'($urandom_range(255)), 1'b1);
      else feed_byte(stt_pkg::CH_NUL, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: every token kind but the parentheses, skips, collapsing, escapes, all errors,
  // both ways of ending the text. Typed expectations are the obvious ones:
  // positions after reset, and the error/flush lexemes at end of text.
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [35] = '{
    '{stt_pkg::CH_LBRACE,    1'b0, 1'b1,
      '{stt_pkg::KIND_LBRACE, stt_pkg::CH_LBRACE, 16'd0, 16'd0, 1'b1, 1'b1,
        stt_pkg::ERR_NONE, 1'b1}},
    '{stt_pkg::CH_SPACE,     1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_TAB,       1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_SPACE,     1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_CR,        1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_RBRACE,    1'b0, 1'b0, NO_LEXEME},   // collapsed space, then brace
    '{stt_pkg::CH_UPPER_A,   1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_UNDERSCORE, 1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_LF,        1'b0, 1'b0, NO_LEXEME},   // identifier tail and newline
    '{stt_pkg::CH_DQUOTE,    1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_BACKSLASH, 1'b0, 1'b0, NO_LEXEME},
    '{"q",                   1'b0, 1'b0, NO_LEXEME},   // bad escape, q rescanned
    '{stt_pkg::CH_SQUOTE,    1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_BACKSLASH, 1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_LOWER_N,   1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_LF,        1'b0, 1'b0, NO_LEXEME},   // newline inside a string
    '{stt_pkg::CH_HASH,      1'b0, 1'b0, NO_LEXEME},
    '{8'hFF,                 1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_LF,        1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_BACKSLASH, 1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_LBRACE,    1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_BACKSLASH, 1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_RBRACE,    1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_BACKSLASH, 1'b0, 1'b0, NO_LEXEME},
    '{8'h80,                 1'b0, 1'b0, NO_LEXEME},   // lone backslash, unknown byte
    '{stt_pkg::CH_SQUOTE,    1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_BACKSLASH, 1'b0, 1'b0, NO_LEXEME},
    '{8'hFF,                 1'b1, 1'b1,               // end right after a backslash
      '{stt_pkg::KIND_STRING, stt_pkg::CH_NUL, 16'd3, 16'd7, 1'b0, 1'b1,
        stt_pkg::ERR_END_ESCAPE, 1'b1}},
    '{stt_pkg::CH_DQUOTE,    1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_LOWER_Z,   1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_NUL,       1'b0, 1'b1,               // zero byte inside a string
      '{stt_pkg::KIND_STRING, stt_pkg::CH_NUL, 16'd0, 16'd0, 1'b0, 1'b1,
        stt_pkg::ERR_UNTERM, 1'b1}},
    '{stt_pkg::CH_LOWER_Z,   1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_NUL,       1'b0, 1'b1,
      '{stt_pkg::KIND_IDENT, stt_pkg::CH_LOWER_Z, 16'd0, 16'd0, 1'b1, 1'b1,
        stt_pkg::ERR_NONE, 1'b1}},
    '{stt_pkg::CH_SPACE,     1'b0, 1'b0, NO_LEXEME},
    '{stt_pkg::CH_UPPER_Z,   1'b1, 1'b1,               // marker flushes the space
      '{stt_pkg::KIND_SPACE, stt_pkg::CH_SPACE, 16'd0, 16'd0, 1'b1, 1'b1,
        stt_pkg::ERR_NONE, 1'b1}}
  };

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    int send_pct [4];
    int stall_pct [4];
    int unsigned phase_start;
    send_pct  = '{0, 77, 0, 34};
    stall_pct = '{0, 0, 77, 34};

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    text_byte_i     = 8'h00;
    end_of_text_i   = 1'b0;
    out_stall_i     = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_tag        = 0;
    hold_seen       = 0;
    hold_left       = 0;
    items_fed       = 0;
    lexemes_checked = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    clear_scanner();

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows, mild idling on both sides
    sender_idle_pct = 20;
    recv_stall_pct  = 20;
    foreach (directed_rows[i])
      feed_byte(directed_rows[i].ch, directed_rows[i].eot, directed_rows[i].typed,
                directed_rows[i].exp);
    wait_drained();

    // random tokens under each idling mix; drain between mixes
    for (int m = 0; m < 4; m++) begin
      sender_idle_pct = send_pct[m];
      recv_stall_pct  = stall_pct[m];
      phase_start     = items_fed;
      while (items_fed - phase_start < PHASE_BYTES) feed_random_token();
      wait_drained();
    end

    // back-pressure: receiver holds off while bytes keep coming, so the
    // result queue fills and the input stalls
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_tag++;
    repeat (10) begin
      feed_byte(stt_pkg::CH_LBRACE, 1'b0);
      feed_byte(stt_pkg::CH_SPACE, 1'b0);
      feed_byte(rand_word_char(), 1'b0);
      feed_byte(stt_pkg::CH_RPAREN, 1'b0);
    end
    wait_drained();

    if (pending_lexemes.size() != 0) begin
      mismatch_count += pending_lexemes.size();
      $display("%0d predicted lexemes never arrived", pending_lexemes.size());
    end

    $display("fed %0d bytes (directed rows, four idling mixes, long receiver hold-off)",
             items_fed);
    $display("checked %0d lexeme transactions, %0d mismatches", lexemes_checked,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
